/* rtl/syslog_payload_classifier_unit_defines.svh */
// ----------------------------------------------------------------------------
// Syslog payload classifier assertion macros
// Shared assertion forms; the using module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef SYSLOG_PAYLOAD_CLASSIFIER_UNIT_DEFINES_SVH
`define SYSLOG_PAYLOAD_CLASSIFIER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spc_pkg.sv */
// ----------------------------------------------------------------------------
// Syslog payload classifier package
// Shared types, register codes, characters and the text pattern table.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int MAX_PRI_DIGITS_DEF = 4;
  localparam int NUM_PAT            = 14;
  localparam int PAT_BITS           = 96;
  localparam int CFG_AW             = 3;

  localparam logic [10:0] MIN_LEN_RST = 11'd20;
  localparam logic [15:0] MAX_LEN_RST = 16'd1024;

  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;

  localparam logic [NUM_PAT-1:0] ALL_ALIVE = '1;

  typedef enum logic [2:0] {
    PH_IDLE, PH_DIGITS, PH_AFTER_GT, PH_TEXT, PH_DECIDED
  } phase_t;

  typedef enum logic [2:0] {
    V_NONE, V_LAST, V_SNORT, V_MONTH, V_REJECT
  } verdict_t;

  typedef enum logic [1:0] {
    MK_NONE, MK_LAST, MK_SNORT, MK_MONTH
  } match_kind_t;

  typedef enum logic {
    REG_MIN_LEN, REG_MAX_LEN
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] min_len;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        is_syslog;
    match_kind_t kind;
  } res_t;

  // Pattern text, left aligned, first character in the top byte.
  function automatic logic [PAT_BITS-1:0] pat_str(input logic [3:0] k);
    logic [PAT_BITS-1:0] s;
    case (k)
      4'd0:    s = "last message";
      4'd1:    s = {"snort: ", 40'h0};
      4'd2:    s = {"Jan", 72'h0};
      4'd3:    s = {"Feb", 72'h0};
      4'd4:    s = {"Mar", 72'h0};
      4'd5:    s = {"Apr", 72'h0};
      4'd6:    s = {"May", 72'h0};
      4'd7:    s = {"Jun", 72'h0};
      4'd8:    s = {"Jul", 72'h0};
      4'd9:    s = {"Aug", 72'h0};
      4'd10:   s = {"Sep", 72'h0};
      4'd11:   s = {"Oct", 72'h0};
      4'd12:   s = {"Nov", 72'h0};
      4'd13:   s = {"Dec", 72'h0};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] pat_len(input logic [3:0] k);
    logic [3:0] n;
    case (k)
      4'd0:    n = 4'd12;
      4'd1:    n = 4'd7;
      default: n = 4'd3;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] pat_char(input logic [3:0] k, input logic [3:0] off);
    logic [PAT_BITS-1:0] s;
    s = pat_str(k) << {off, 3'b000};
    return s[PAT_BITS-1 -: 8];
  endfunction

endpackage

/* rtl/syslog_payload_classifier_unit.sv */
// ----------------------------------------------------------------------------
// An accepted last beat is held in the input register; its result beat is then registered onto out_valid.
// Throughput: 1 byte per cycle unless a stalled result raises in_stall; the parser state updates once per byte.
// Reset: synchronous, active low; packet state cleared, length window 20 / 1024.
// Syslog payload classifier: input register, parser, result register.
// ----------------------------------------------------------------------------
module syslog_payload_classifier_unit
  import spc_pkg::*;
#(
  parameter int MAX_PRIORITY_DIGITS = MAX_PRI_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_byte,
  input  logic              in_last_byte,
  input  logic [15:0]       in_packet_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_is_syslog,
  output logic [1:0]        out_match_kind,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t        cfg;
  res_t        res;
  logic        adv;
  logic        fire;

  logic        s1_valid_r;
  logic [7:0]  s1_data_r;
  logic        s1_first_r;
  logic        s1_last_r;
  logic [15:0] s1_len_r;

  logic        out_valid_r;
  logic        out_is_syslog_r;
  match_kind_t out_kind_r;

  assign pready   = 1'b1;
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  spc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  spc_parse #(
    .MAX_PRIORITY_DIGITS (MAX_PRIORITY_DIGITS)
  ) u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .data_byte     (s1_data_r),
    .first_byte    (s1_first_r),
    .last_byte     (s1_last_r),
    .packet_length (s1_len_r),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r  <= in_data_byte;
      s1_first_r <= in_first_byte;
      s1_last_r  <= in_last_byte;
      s1_len_r   <= in_packet_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_is_syslog_r <= res.is_syslog;
      out_kind_r      <= res.kind;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_syslog  = out_is_syslog_r;
  assign out_match_kind = out_kind_r;

endmodule

/* rtl/spc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Syslog payload classifier configuration registers
// Bus-side register file holding the payload length window.
// ----------------------------------------------------------------------------
module spc_cfg_regs
  import spc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  logic [10:0] min_len_r;
  logic [15:0] max_len_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_LEN: min_len_r <= pwdata[10:0];
        REG_MAX_LEN: max_len_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_LEN: prdata = {21'd0, min_len_r};
      REG_MAX_LEN: prdata = {16'd0, max_len_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg.min_len = min_len_r;
  assign cfg.max_len = max_len_r;

endmodule

/* rtl/spc_parse.sv */
// ----------------------------------------------------------------------------
// Syslog payload classifier parser
// Per-packet header and text pattern state; one byte is consumed per beat.
// ----------------------------------------------------------------------------
`include "syslog_payload_classifier_unit_defines.svh"

module spc_parse
  import spc_pkg::*;
#(
  parameter int MAX_PRIORITY_DIGITS = MAX_PRI_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [15:0] packet_length,
  input  cfg_t        cfg,
  output res_t        res
);

  localparam int DIGIT_W = $clog2(MAX_PRIORITY_DIGITS + 1);

  logic [15:0]        byte_pos_r, byte_pos_nxt, byte_pos_p;
  phase_t             phase_r, phase_nxt, phase_p;
  logic [DIGIT_W-1:0] digit_cnt_r, digit_cnt_nxt, digit_cnt_p;
  logic [3:0]         text_off_r, text_off_nxt, text_off_p;
  logic [NUM_PAT-1:0] alive_r, alive_nxt, alive_p;
  verdict_t           verdict_r, verdict_nxt, verdict_p;

  logic [NUM_PAT-1:0] hit;
  logic [NUM_PAT-1:0] done;
  logic               len_ok;
  logic               is_digit;
  logic               do_text;
  logic               emit;
  verdict_t           kind_v;

  // Every live pattern is compared against the byte at the current text offset.
  always_comb begin
    for (int k = 0; k < NUM_PAT; k++) begin
      hit[k]  = alive_r[k] && (text_off_r < pat_len(4'(k))) &&
                (pat_char(4'(k), text_off_r) == data_byte);
      done[k] = hit[k] && ((text_off_r + 4'd1) == pat_len(4'(k)));
    end
  end

  assign len_ok   = (packet_length > {5'd0, cfg.min_len}) && (packet_length <= cfg.max_len);
  assign is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign emit     = fire && last_byte && (first_byte || (phase_r != PH_IDLE));

  always_comb begin
    if (done[0]) begin
      kind_v = V_LAST;
    end else if (done[1]) begin
      kind_v = V_SNORT;
    end else begin
      kind_v = V_MONTH;
    end
  end

  // State after the current byte, before any end-of-packet clear.
  always_comb begin
    byte_pos_p  = byte_pos_r;
    phase_p     = phase_r;
    digit_cnt_p = digit_cnt_r;
    text_off_p  = text_off_r;
    alive_p     = alive_r;
    verdict_p   = verdict_r;
    do_text     = 1'b0;
    if (first_byte) begin
      byte_pos_p  = 16'd1;
      digit_cnt_p = '0;
      text_off_p  = '0;
      alive_p     = ALL_ALIVE;
      verdict_p   = V_NONE;
      if (len_ok && (data_byte == CH_LT)) begin
        phase_p = PH_DIGITS;
      end else begin
        phase_p   = PH_DECIDED;
        verdict_p = V_REJECT;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_DIGITS: begin
          if (is_digit && (digit_cnt_r < DIGIT_W'(MAX_PRIORITY_DIGITS))) begin
            digit_cnt_p = digit_cnt_r + 1'b1;
          end else if (data_byte == CH_GT) begin
            phase_p = PH_AFTER_GT;
          end else begin
            phase_p   = PH_DECIDED;
            verdict_p = V_REJECT;
          end
        end
        PH_AFTER_GT: begin
          phase_p = PH_TEXT;
          do_text = (data_byte != CH_SP);
        end
        PH_TEXT:    do_text = 1'b1;
        PH_DECIDED: ;
        default: ;
      endcase
      if (do_text) begin
        alive_p = hit;
        if (|done) begin
          phase_p   = PH_DECIDED;
          verdict_p = (byte_pos_r < packet_length) ? kind_v : V_REJECT;
        end else if (hit == '0) begin
          phase_p   = PH_DECIDED;
          verdict_p = V_REJECT;
        end else begin
          text_off_p = text_off_r + 4'd1;
        end
      end
      if ((phase_r != PH_IDLE) && (byte_pos_r != 16'hFFFF)) begin
        byte_pos_p = byte_pos_r + 16'd1;
      end
    end
  end

  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    phase_nxt     = phase_r;
    digit_cnt_nxt = digit_cnt_r;
    text_off_nxt  = text_off_r;
    alive_nxt     = alive_r;
    verdict_nxt   = verdict_r;
    if (emit) begin
      byte_pos_nxt  = '0;
      phase_nxt     = PH_IDLE;
      digit_cnt_nxt = '0;
      text_off_nxt  = '0;
      alive_nxt     = ALL_ALIVE;
      verdict_nxt   = V_NONE;
    end else if (fire) begin
      byte_pos_nxt  = byte_pos_p;
      phase_nxt     = phase_p;
      digit_cnt_nxt = digit_cnt_p;
      text_off_nxt  = text_off_p;
      alive_nxt     = alive_p;
      verdict_nxt   = verdict_p;
    end
  end

  always_comb begin
    res.valid     = emit;
    res.is_syslog = 1'b0;
    res.kind      = MK_NONE;
    case (verdict_p)
      V_LAST: begin
        res.is_syslog = 1'b1;
        res.kind      = MK_LAST;
      end
      V_SNORT: begin
        res.is_syslog = 1'b1;
        res.kind      = MK_SNORT;
      end
      V_MONTH: begin
        res.is_syslog = 1'b1;
        res.kind      = MK_MONTH;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      phase_r     <= PH_IDLE;
      digit_cnt_r <= '0;
      text_off_r  <= '0;
      alive_r     <= ALL_ALIVE;
      verdict_r   <= V_NONE;
    end else begin
      byte_pos_r  <= byte_pos_nxt;
      phase_r     <= phase_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      text_off_r  <= text_off_nxt;
      alive_r     <= alive_nxt;
      verdict_r   <= verdict_nxt;
    end
  end

  `SPC_ASSERT_IMP(a_digit_bound, 1'b1, digit_cnt_r <= DIGIT_W'(MAX_PRIORITY_DIGITS), "priority digit count overran its bound")
  `SPC_ASSERT_IMP(a_idle_clean, phase_r == PH_IDLE, (verdict_r == V_NONE) && (byte_pos_r == 16'd0), "idle parser holds stale packet state")
  `SPC_ASSERT_IMP(a_decided_verdict, phase_r == PH_DECIDED, verdict_r != V_NONE, "decided packet has no verdict")
  `SPC_ASSERT_NXT(a_first_opens, fire && first_byte && !last_byte, phase_r != PH_IDLE, "first byte did not open a packet")

endmodule
